/* sv/assert_macros.svh */
// Assertion macros for the checker file.
// Depends on nothing; every use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bsl_pkg.sv */
// Types and constants of the byte stream lexer: token kinds, scanner states,
// character codes and the result record. No dependencies.
package bsl_pkg;

  localparam int KIND_W = 4;
  localparam int LEN_W  = 6;
  localparam int OFS_W  = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT    = 4'd0,
    KIND_LIT    = 4'd1,
    KIND_ID     = 4'd2,
    KIND_PLUS   = 4'd3,
    KIND_MINUS  = 4'd4,
    KIND_STAR   = 4'd5,
    KIND_SLASH  = 4'd6,
    KIND_ASSIGN = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_SEMI   = 4'd10,
    KIND_ERROR  = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_I    = 3'd1,
    ST_IN   = 3'd2,
    ST_INT  = 3'd3,
    ST_ID   = 3'd4,
    ST_LIT  = 3'd5,
    ST_OP   = 3'd6
  } state_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  length;
    logic [OFS_W-1:0]  start;
    logic [7:0]        bad;
    logic              ovf;
    logic              last;
  } res_t;

endpackage

/* sv/byte_stream_lexer_top.sv */
// Byte stream lexer: DFA scanner over one text byte per beat, with a small
// result queue on the output side. Depends on bsl_pkg.
//
//  channel  side    payload
//  s_axis   in      tdata[7:0] text_byte
//  m_axis   out     tuser token_kind, tdata token fields, tlast last_of_run
//
// One byte is taken per clock while s_axis_tready is high; it is scanned in the same
// cycle and its results are registered into a 4-entry queue that feeds m_axis.
// A byte that ends a token and is itself bad yields two results, which take
// two output beats; s_axis_tready drops while fewer than two queue slots are free.
// rst is synchronous: it clears the DFA, the byte position and the queue.
// Output stalls hold the queue; input keeps flowing until fewer than two slots are free.
module byte_stream_lexer_top #(
  parameter int TEXT_CAPACITY = 64,
  parameter int OFFSET_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] text_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [5:0] token_length, [21:6] start_offset, [29:22] bad_byte,
  // [30] length_overflow, [31] zero
  output logic [31:0]                 m_axis_tdata,
  output logic [bsl_pkg::KIND_W-1:0]  m_axis_tuser,   // [3:0] token_kind
  output logic                        m_axis_tlast    // last_of_run
);
  import bsl_pkg::*;

  localparam int LW = $clog2(TEXT_CAPACITY);
  localparam logic [LW-1:0] LEN_MAX = LW'(TEXT_CAPACITY - 1);

  // Scanner state
  state_t                 state, state_next;
  kind_t                  pkind, kind_next;
  logic [LW-1:0]          plen, len_next;
  logic [OFFSET_BITS-1:0] pstart, start_next;
  logic                   povf, ovf_next;
  logic [OFFSET_BITS-1:0] pos;

  // Result queue
  res_t           qmem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;

  logic [7:0] byte_in;
  logic       in_fire, pop;
  logic       is_digit, is_alpha, is_alnum, is_space;
  logic       op_hit;
  kind_t      op_kind;
  logic       ended, take, rescan, clear_pend, flush_hit, err_hit;
  logic [1:0] push_n;
  res_t       res_flush, res_err, res0, res1;

  logic [OFFSET_BITS+OFS_W-1:0] pstart_x, pos_x;
  logic [LW+LEN_W-1:0]          plen_x;

  assign byte_in  = s_axis_tdata;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign pop      = m_axis_tvalid && m_axis_tready;

  assign is_digit = byte_in inside {[CH_0:CH_9]};
  assign is_alpha = byte_in inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
  assign is_alnum = is_digit || is_alpha;
  assign is_space = byte_in inside {CH_SP, [CH_TAB:CH_CR]};

  always_comb begin
    op_hit  = 1'b1;
    op_kind = KIND_PLUS;
    case (byte_in)
      CH_PLUS:   op_kind = KIND_PLUS;
      CH_MINUS:  op_kind = KIND_MINUS;
      CH_STAR:   op_kind = KIND_STAR;
      CH_SLASH:  op_kind = KIND_SLASH;
      CH_ASSIGN: op_kind = KIND_ASSIGN;
      CH_LPAREN: op_kind = KIND_LPAREN;
      CH_RPAREN: op_kind = KIND_RPAREN;
      CH_SEMI:   op_kind = KIND_SEMI;
      default:   op_hit  = 1'b0;
    endcase
  end

  // DFA step: next state and the results this byte causes.
  always_comb begin
    state_next = state;
    kind_next  = pkind;
    len_next   = plen;
    start_next = pstart;
    ovf_next   = povf;
    ended      = 1'b0;
    take       = 1'b0;
    rescan     = 1'b0;
    clear_pend = 1'b0;
    flush_hit  = 1'b0;
    err_hit    = 1'b0;

    if (byte_in == CH_NUL) begin
      flush_hit  = (state != ST_IDLE) && (plen != '0);
      clear_pend = 1'b1;
    end else begin
      case (state)
        ST_I: begin
          if (byte_in == CH_N) begin
            state_next = ST_IN;
            take       = 1'b1;
          end else if (is_alnum) begin
            state_next = ST_ID;
            take       = 1'b1;
          end else begin
            ended = 1'b1;
          end
        end
        ST_IN: begin
          if (byte_in == CH_T) begin
            state_next = ST_INT;
            kind_next  = KIND_INT;
            take       = 1'b1;
          end else if (is_alnum) begin
            state_next = ST_ID;
            take       = 1'b1;
          end else begin
            ended = 1'b1;
          end
        end
        ST_INT: begin
          if (is_alnum) begin
            state_next = ST_ID;
            kind_next  = KIND_ID;
            take       = 1'b1;
          end else begin
            ended = 1'b1;
          end
        end
        ST_ID: begin
          if (is_alnum) take = 1'b1;
          else ended = 1'b1;
        end
        ST_LIT: begin
          if (is_digit) take = 1'b1;
          else ended = 1'b1;
        end
        ST_OP: ended = 1'b1;
        default: begin
          state_next = ST_IDLE;
          rescan     = 1'b1;
        end
      endcase
      if (ended) begin
        flush_hit  = (plen != '0);
        clear_pend = 1'b1;
        rescan     = 1'b1;
      end
    end

    if (clear_pend) begin
      state_next = ST_IDLE;
      kind_next  = KIND_INT;
      len_next   = '0;
      start_next = '0;
      ovf_next   = 1'b0;
    end

    // Saturate the length and flag the truncation.
    if (take) begin
      if (plen < LEN_MAX) len_next = plen + LW'(1);
      else ovf_next = 1'b1;
    end

    // Rescan the byte from the initial state.
    if (rescan) begin
      len_next   = LW'(1);
      start_next = pos;
      ovf_next   = 1'b0;
      if (is_digit) begin
        state_next = ST_LIT;
        kind_next  = KIND_LIT;
      end else if (byte_in == CH_I) begin
        state_next = ST_I;
        kind_next  = KIND_ID;
      end else if (op_hit) begin
        state_next = ST_OP;
        kind_next  = op_kind;
      end else if (is_alpha) begin
        state_next = ST_ID;
        kind_next  = KIND_ID;
      end else begin
        state_next = ST_IDLE;
        kind_next  = KIND_INT;
        len_next   = '0;
        start_next = '0;
        err_hit    = !is_space;
      end
    end
  end

  assign pstart_x = {{OFS_W{1'b0}}, pstart};
  assign pos_x    = {{OFS_W{1'b0}}, pos};
  assign plen_x   = {{LEN_W{1'b0}}, plen};

  always_comb begin
    res_flush.kind   = pkind;
    res_flush.length = plen_x[LEN_W-1:0];
    res_flush.start  = pstart_x[OFS_W-1:0];
    res_flush.bad    = 8'h00;
    res_flush.ovf    = povf;
    res_flush.last   = 1'b0;

    res_err.kind   = KIND_ERROR;
    res_err.length = LEN_W'(1);
    res_err.start  = pos_x[OFS_W-1:0];
    res_err.bad    = byte_in;
    res_err.ovf    = 1'b0;
    res_err.last   = 1'b1;

    push_n    = {1'b0, flush_hit} + {1'b0, err_hit};
    res0      = flush_hit ? res_flush : res_err;
    res0.last = (push_n == 2'd1);
    res1      = res_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pkind  <= KIND_INT;
      plen   <= '0;
      pstart <= '0;
      povf   <= 1'b0;
      pos    <= '0;
    end else if (in_fire) begin
      state  <= state_next;
      pkind  <= kind_next;
      plen   <= len_next;
      pstart <= start_next;
      povf   <= ovf_next;
      pos    <= (byte_in == CH_NUL) ? '0 : pos + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (push_n != 2'd0) qmem[wr_ptr] <= res0;
      if (push_n == 2'd2) qmem[wr_ptr + QAW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) wr_ptr <= wr_ptr + QAW'(push_n);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + QCW'(in_fire ? push_n : 2'd0) - QCW'(pop);
    end
  end

  assign s_axis_tready = (count <= QCW'(QDEPTH - 2));
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {1'b0, qmem[rd_ptr].ovf, qmem[rd_ptr].bad,
                          qmem[rd_ptr].start, qmem[rd_ptr].length};
  assign m_axis_tuser  = qmem[rd_ptr].kind;
  assign m_axis_tlast  = qmem[rd_ptr].last;

endmodule

/* sv/bsl_checker.sv */
// Port-level checks for byte_stream_lexer_top, bound to every instance.
// Depends on bsl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [7:0]                  s_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [31:0]                 m_axis_tdata,
  input logic [bsl_pkg::KIND_W-1:0]  m_axis_tuser,
  input logic                        m_axis_tlast
);
  import bsl_pkg::*;

  logic                          err_beat, tok_beat;
  logic                          err_ok, tok_ok;
  logic [32+bsl_pkg::KIND_W:0]   res_word;

  assign err_beat = m_axis_tvalid && (m_axis_tuser == KIND_ERROR);
  assign tok_beat = m_axis_tvalid && (m_axis_tuser != KIND_ERROR);

  assign err_ok   = (m_axis_tdata[5:0] == 6'd1) && !m_axis_tdata[30] && m_axis_tlast;
  assign tok_ok   = (m_axis_tdata[29:22] == 8'h00) && (m_axis_tdata[5:0] != 6'd0) &&
                    (m_axis_tuser <= KIND_SEMI);
  assign res_word = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // An error beat carries one character and is always the last of its byte.
  `ASSERT_CLK(a_err_shape, err_beat |-> err_ok, "error beat malformed")

  // Tokens never carry a bad byte and never have zero length.
  `ASSERT_CLK(a_tok_shape, tok_beat |-> tok_ok, "token beat malformed")

  // Hold a stalled result.
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(res_word), "stalled result changed")

  // Reset empties the result queue.
  `ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid && s_axis_tready, "queue not empty after reset")

endmodule

bind byte_stream_lexer_top bsl_checker u_bsl_checker (.*);

/* verif/tb_top.sv */
// Self-checking bench for byte_stream_lexer_top: streams text bytes in, predicts the
// token records in a local scanner model and checks every output beat against it.
// Depends on bsl_pkg and byte_stream_lexer_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsl_pkg::*;

  localparam int TEXT_CAP    = 64;
  localparam int TOKEN_MAX   = TEXT_CAP - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 1400;

  localparam logic [7:0] OP_CHARS [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                          CH_ASSIGN, CH_LPAREN, CH_RPAREN, CH_SEMI};

  typedef struct {
    logic [7:0] b;
    bit         calm;   // no idling on either side while this byte is in play
    bit         hold;   // marker: hold the input until every token has drained
  } feed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic        m_axis_tlast;

  byte_stream_lexer_top #(
    .TEXT_CAPACITY(TEXT_CAP),
    .OFFSET_BITS  (16)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  feed_t       text_feed[$];
  res_t        due_tokens[$];
  int          faults = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          calm_now = 1'b0;
  bit          calm_fill = 1'b0;
  int unsigned cycles = 0;

  // Scanner model state, matching the block right after reset.
  state_t      lx_state = ST_IDLE;
  kind_t       lx_kind  = KIND_INT;
  logic [5:0]  lx_len   = '0;
  logic [15:0] lx_start = '0;
  logic [15:0] lx_pos   = '0;
  logic        lx_ovf   = 1'b0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit op_of(input logic [7:0] c, output kind_t k);
    bit hit;
    hit = 1'b1;
    k = KIND_ERROR;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_ASSIGN: k = KIND_ASSIGN;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_SEMI:   k = KIND_SEMI;
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic bit is_lexeme(input logic [7:0] c);
    kind_t k;
    return is_alnum(c) || is_blank(c) || op_of(c, k);
  endfunction

  function automatic void add_result(input kind_t k, input logic [5:0] len,
                                     input logic [15:0] at, input logic [7:0] bad,
                                     input logic ovf);
    res_t r;
    r.kind   = k;
    r.length = len;
    r.start  = at;
    r.bad    = bad;
    r.ovf    = ovf;
    r.last   = 1'b0;
    due_tokens.push_back(r);
  endfunction

  function automatic void emit_pending();
    if (lx_state != ST_IDLE && lx_len != 0)
      add_result(lx_kind, lx_len, lx_start, 8'h00, lx_ovf);
    lx_state = ST_IDLE;
    lx_kind  = KIND_INT;
    lx_len   = '0;
    lx_start = '0;
    lx_ovf   = 1'b0;
  endfunction

  function automatic void grow_token();
    if (lx_len < TOKEN_MAX) lx_len++;
    else lx_ovf = 1'b1;
  endfunction

  function automatic void enter_token(input state_t s, input kind_t k,
                                      input logic [15:0] at);
    lx_state = s;
    lx_kind  = k;
    lx_len   = 6'd1;
    lx_start = at;
    lx_ovf   = 1'b0;
  endfunction

  function automatic void classify_first(input logic [7:0] c, input logic [15:0] at);
    kind_t k;
    if (is_digit(c)) enter_token(ST_LIT, KIND_LIT, at);
    else if (c == CH_I) enter_token(ST_I, KIND_ID, at);
    else if (op_of(c, k)) enter_token(ST_OP, k, at);
    else if (is_alnum(c)) enter_token(ST_ID, KIND_ID, at);
    else if (!is_blank(c)) add_result(KIND_ERROR, 6'd1, at, c, 1'b0);
  endfunction

  // Advance the scanner model by one text byte and queue the tokens it closes.
  function automatic void scan_byte(input logic [7:0] c);
    int          had;
    logic [15:0] here;
    bit          ended;
    res_t        tail;
    had   = due_tokens.size();
    here  = lx_pos;
    ended = 1'b0;
    if (c == CH_NUL) begin
      emit_pending();
      lx_pos = '0;
    end else begin
      case (lx_state)
        ST_I: begin
          if (c == CH_N) begin
            lx_state = ST_IN;
            grow_token();
          end else if (is_alnum(c)) begin
            lx_state = ST_ID;
            grow_token();
          end else ended = 1'b1;
        end
        ST_IN: begin
          if (c == CH_T) begin
            lx_state = ST_INT;
            lx_kind  = KIND_INT;
            grow_token();
          end else if (is_alnum(c)) begin
            lx_state = ST_ID;
            grow_token();
          end else ended = 1'b1;
        end
        ST_INT: begin
          if (is_alnum(c)) begin
            lx_state = ST_ID;
            lx_kind  = KIND_ID;
            grow_token();
          end else ended = 1'b1;
        end
        ST_ID: begin
          if (is_alnum(c)) grow_token();
          else ended = 1'b1;
        end
        ST_LIT: begin
          if (is_digit(c)) grow_token();
          else ended = 1'b1;
        end
        ST_OP: ended = 1'b1;
        default: begin
          lx_state = ST_IDLE;
          classify_first(c, here);
        end
      endcase
      // The terminating byte is scanned again from the idle state.
      if (ended) begin
        emit_pending();
        classify_first(c, here);
      end
      lx_pos = here + 16'd1;
    end
    if (due_tokens.size() > had) begin
      tail = due_tokens.pop_back();
      tail.last = 1'b1;
      due_tokens.push_back(tail);
    end
  endfunction

  function automatic void put(input logic [7:0] c);
    text_feed.push_back('{b: c, calm: calm_fill, hold: 1'b0});
  endfunction

  function automatic void put_hold();
    text_feed.push_back('{b: CH_NUL, calm: 1'b0, hold: 1'b1});
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? CH_LA + 8'(r) : CH_UA + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 9) < 3) ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SP : CH_TAB + 8'(r);
  endfunction

  // Append one token-shaped chunk of text and an optional separator.
  function automatic void add_token(input bit allow_end);
    int         n;
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1: begin
        put(CH_I);
        put(CH_N);
        put(CH_T);
      end
      2: put(CH_I);
      3: begin
        put(CH_I);
        put(CH_N);
      end
      4, 5, 6: begin
        put(rand_letter());
        n = $urandom_range(0, 7);
        repeat (n) put(rand_alnum());
      end
      7, 8, 9: begin
        n = $urandom_range(1, 6);
        repeat (n) put(rand_digit());
      end
      10, 11, 12, 13: put(OP_CHARS[$urandom_range(0, 7)]);
      14: begin
        do c = 8'($urandom_range(1, 255)); while (is_lexeme(c));
        put(c);
      end
      15: begin
        // now and then a run around the length cap
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(TOKEN_MAX - 3, TOKEN_MAX + 7) : 2;
        if ($urandom_range(0, 1)) begin
          put(rand_letter());
          repeat (n - 1) put(rand_alnum());
        end else begin
          repeat (n) put(rand_digit());
        end
      end
      16, 17: put(rand_blank());
      18: put(allow_end ? CH_NUL : CH_SP);
      default: begin
        put(CH_I);
        put(rand_alnum());
      end
    endcase
    case ($urandom_range(0, 3))
      0: ;
      1: put(CH_SP);
      2: put(rand_blank());
      default: begin
        put(rand_blank());
        put(rand_blank());
      end
    endcase
  endfunction

  function automatic void log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Driver: present queued text bytes, predicting each one as its beat is taken.
  always @(posedge clk) begin : drive
    feed_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      <= 0;
      calm_now      <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (text_feed.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (text_feed[0].hold) begin
          s_axis_tvalid <= 1'b0;
          if (due_tokens.size() == 0) void'(text_feed.pop_front());
        end else begin
          nxt = text_feed.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.b;
          calm_now      <= nxt.calm;
          gap_left      <= nxt.calm ? 0 : $urandom_range(0, 4);
        end
      end
    end
  end

  // Monitor: take token beats with random stalls and check them in order.
  always @(posedge clk) begin : observe
    res_t want;
    int   wait_n;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      wait_n = stall_left;
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_tokens.size() == 0) begin
          log_fault($sformatf("unexpected token: kind %0d len %0d start %0d bad %0h",
                              m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6],
                              m_axis_tdata[29:22]));
        end else begin
          want = due_tokens.pop_front();
          if (m_axis_tuser != want.kind || m_axis_tdata[5:0] != want.length ||
              m_axis_tdata[21:6] != want.start || m_axis_tdata[29:22] != want.bad ||
              m_axis_tdata[30] != want.ovf || m_axis_tlast != want.last) begin
            log_fault($sformatf({"token differs: want kind %0d len %0d start %0d bad %0h",
                                 " ovf %0b last %0b, got kind %0d len %0d start %0d",
                                 " bad %0h ovf %0b last %0b"},
                                want.kind, want.length, want.start, want.bad, want.ovf,
                                want.last, m_axis_tuser, m_axis_tdata[5:0],
                                m_axis_tdata[21:6], m_axis_tdata[29:22], m_axis_tdata[30],
                                m_axis_tlast));
          end
        end
        wait_n = calm_now ? 0 : $urandom_range(0, 4);
      end
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= wait_n - 1;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("byte_stream_lexer_top: mismatch");
      $finish;
    end
  end

  initial begin
    string lead;
    int    mark;
    // Keyword, lone i and in, ids that branch off the keyword path, all operators,
    // an operator ended by a bad byte, a high bad byte, then end of text.
    lead = "int i in in9 intx=(7)/-*+;#";
    for (int k = 0; k < lead.len(); k++) put(lead[k]);
    put(8'hFF);
    put(CH_NUL);
    put(CH_NUL);
    put_hold();

    // Random text, bad bytes included; one forced overlong literal up front.
    repeat (TOKEN_MAX + 5) put(rand_digit());
    put(CH_SP);
    mark = text_feed.size();
    while (text_feed.size() - mark < RANDOM_BYTES) begin
      if ($urandom_range(0, 59) == 0) calm_fill = ~calm_fill;
      if ($urandom_range(0, 199) == 0) put_hold();
      add_token(1'b1);
    end
    put(CH_NUL);
    put_hold();

    calm_fill = 1'b0;
    repeat (30) add_token(1'b1);
    put(CH_I);
    put(CH_N);
    put(CH_NUL);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (text_feed.size() != 0 || s_axis_tvalid || due_tokens.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (faults == 0 && due_tokens.size() == 0) begin
      $display("byte_stream_lexer_top: match");
    end else begin
      $display("byte_stream_lexer_top: mismatch");
    end
    $finish;
  end

endmodule
